### hdl/imm_pkg.sv
package imm_pkg;

  // default matrix capacity per dimension
  localparam int MAX_DIM_DEF = 8;

  // word and field widths
  localparam int VALUE_W   = 32;
  localparam int FUNC_W    = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_IDX_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 2'd3;

  // function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic issue;
    logic clear;
  } ctrl_t;

  // sequencer to output register
  typedef struct packed {
    logic                 valid;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
    logic                 err;
  } emit_t;

endpackage

### hdl/imm_mac.sv
module imm_mac #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  imm_pkg::ctrl_t                    ctrl,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic signed [imm_pkg::VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]                 rd_a_addr,
  input  logic [ADDR_W-1:0]                 rd_b_addr,
  output logic                              busy,
  output logic [imm_pkg::VALUE_W-1:0]       acc
);
  import imm_pkg::*;

  logic [VALUE_W-1:0] a_store [DEPTH];
  logic [VALUE_W-1:0] b_store [DEPTH];
  logic [VALUE_W-1:0] a_rd;
  logic [VALUE_W-1:0] b_rd;
  logic [VALUE_W-1:0] mul;
  logic               rd_valid;
  logic               mul_valid;

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (ctrl.wr_a) begin
      a_store[wr_addr] <= wr_data;
    end
    if (ctrl.wr_b) begin
      b_store[wr_addr] <= wr_data;
    end
    if (ctrl.issue) begin
      a_rd <= a_store[rd_a_addr];
      b_rd <= b_store[rd_b_addr];
    end
  end

  // shared multiplier, low word only, then accumulate with wrap
  always_ff @(posedge clk) begin
    mul <= VALUE_W'(a_rd * b_rd);
    if (ctrl.clear) begin
      acc <= '0;
    end else if (mul_valid) begin
      acc <= acc + mul;
    end
  end

  // pipeline occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= ctrl.issue;
      mul_valid <= rd_valid;
    end
  end

  assign busy = rd_valid | mul_valid;

endmodule

### hdl/imm_seq.sv
module imm_seq #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int DIM_W  = $clog2(MAX_DIM + 1),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [imm_pkg::FUNC_W-1:0]  func,
  input  logic [DIM_W-1:0]            ra,
  input  logic [DIM_W-1:0]            ia,
  input  logic [DIM_W-1:0]            rb,
  input  logic [DIM_W-1:0]            cb,
  input  logic                        out_free,
  input  logic                        mac_busy,
  output imm_pkg::ctrl_t              ctrl,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [ADDR_W-1:0]           rd_a_addr,
  output logic [ADDR_W-1:0]           rd_b_addr,
  output imm_pkg::emit_t              emit
);
  import imm_pkg::*;

  localparam int CMP_W = (CNT_W > 2 * DIM_W) ? CNT_W : 2 * DIM_W;

  state_t            state;
  state_t            state_next;
  logic [DIM_W-1:0]  i, i_next;
  logic [DIM_W-1:0]  j, j_next;
  logic [DIM_W-1:0]  k, k_next;
  logic [ADDR_W-1:0] a_row, a_row_next;
  logic [ADDR_W-1:0] a_addr, a_addr_next;
  logic [ADDR_W-1:0] b_addr, b_addr_next;
  logic [CNT_W-1:0]  a_count, a_count_next;
  logic [CNT_W-1:0]  b_count, b_count_next;

  logic accept;
  logic is_compute;
  logic err;
  logic skip_mac;
  logic empty;
  logic last_k;
  logic last_col;
  logic last_row;
  logic done;
  logic start_first;
  logic advance;
  logic a_room;
  logic b_room;

  // status decode
  always_comb begin
    accept      = in_valid && in_ready;
    is_compute  = (func == FUNC_COMPUTE);
    err         = (ia != rb);
    skip_mac    = err || (ia == '0);
    empty       = (ra == '0) || (cb == '0);
    last_k      = (k == ia - DIM_W'(1));
    last_col    = (j == cb - DIM_W'(1));
    last_row    = (i == ra - DIM_W'(1));
    done        = last_row && last_col;
    start_first = (state == S_IDLE) && accept && is_compute && !empty;
    advance     = (state == S_EMIT) && out_free && !done;
    a_room      = CMP_W'(a_count) < (CMP_W'(ra) * CMP_W'(ia));
    b_room      = CMP_W'(b_count) < (CMP_W'(rb) * CMP_W'(cb));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start_first) begin
          state_next = skip_mac ? S_EMIT : S_RUN;
        end
      end
      S_RUN: begin
        if (last_k) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (done) begin
            state_next = S_IDLE;
          end else begin
            state_next = skip_mac ? S_EMIT : S_RUN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == S_IDLE);
    ctrl.wr_a  = accept && (func == FUNC_LOAD_A) && a_room;
    ctrl.wr_b  = accept && (func == FUNC_LOAD_B) && b_room;
    ctrl.issue = (state == S_RUN);
    ctrl.clear = start_first || advance;
    wr_addr    = ctrl.wr_a ? a_count[ADDR_W-1:0] : b_count[ADDR_W-1:0];
    rd_a_addr  = a_addr;
    rd_b_addr  = b_addr;
    emit.valid = (state == S_EMIT) && out_free;
    emit.row   = OUT_IDX_W'(i);
    emit.col   = OUT_IDX_W'(j);
    emit.last  = done;
    emit.err   = err;
  end

  // counters and address walk
  always_comb begin
    i_next       = i;
    j_next       = j;
    k_next       = k;
    a_row_next   = a_row;
    a_addr_next  = a_addr;
    b_addr_next  = b_addr;
    a_count_next = a_count;
    b_count_next = b_count;
    if (ctrl.wr_a) begin
      a_count_next = a_count + CNT_W'(1);
    end
    if (ctrl.wr_b) begin
      b_count_next = b_count + CNT_W'(1);
    end
    if ((state == S_IDLE) && accept && is_compute) begin
      a_count_next = '0;
      b_count_next = '0;
      i_next       = '0;
      j_next       = '0;
      k_next       = '0;
      a_row_next   = '0;
      a_addr_next  = '0;
      b_addr_next  = '0;
    end
    if (state == S_RUN) begin
      k_next      = k + DIM_W'(1);
      a_addr_next = a_addr + ADDR_W'(1);
      b_addr_next = b_addr + ADDR_W'(cb);
    end
    if (advance) begin
      k_next = '0;
      if (last_col) begin
        i_next      = i + DIM_W'(1);
        j_next      = '0;
        a_row_next  = a_row + ADDR_W'(ia);
        a_addr_next = a_row + ADDR_W'(ia);
        b_addr_next = '0;
      end else begin
        j_next      = j + DIM_W'(1);
        a_addr_next = a_row;
        b_addr_next = ADDR_W'(j) + ADDR_W'(1);
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      a_row   <= '0;
      a_addr  <= '0;
      b_addr  <= '0;
      a_count <= '0;
      b_count <= '0;
    end else begin
      state   <= state_next;
      i       <= i_next;
      j       <= j_next;
      k       <= k_next;
      a_row   <= a_row_next;
      a_addr  <= a_addr_next;
      b_addr  <= b_addr_next;
      a_count <= a_count_next;
      b_count <= b_count_next;
    end
  end

endmodule

### hdl/integer_matrix_multiply_top.sv
// load word (func 0 or 1): written to its store while room remains, input stays ready
// compute word: per product element inner_a operand reads, then multiply and
//   accumulate drain, then an emit; on a dimension mismatch or an empty inner
//   dimension each element is emitted without operand reads; one shared multiplier
// results leave through an output register and may wait there while new words enter
// rst is synchronous: control and load counters clear, dimensions go to 8, stores kept
module integer_matrix_multiply_top #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [imm_pkg::FUNC_W-1:0]          func,
  input  logic signed [imm_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [imm_pkg::VALUE_W-1:0]  product,
  output logic [imm_pkg::OUT_IDX_W-1:0]       row_index,
  output logic [imm_pkg::OUT_IDX_W-1:0]       col_index,
  output logic                                last,
  output logic                                dim_error,
  input  logic                                cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]           cfg_data
);
  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0]   rows_a;
  logic [CFG_W-1:0]   inner_a;
  logic [CFG_W-1:0]   rows_b;
  logic [CFG_W-1:0]   cols_b;
  logic [DIM_W-1:0]   ra;
  logic [DIM_W-1:0]   ia;
  logic [DIM_W-1:0]   rb;
  logic [DIM_W-1:0]   cb;
  logic               out_free;
  logic               mac_busy;
  ctrl_t              ctrl;
  emit_t              emit;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_a_addr;
  logic [ADDR_W-1:0]  rd_b_addr;
  logic [VALUE_W-1:0] acc;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a  <= CFG_RESET;
      inner_a <= CFG_RESET;
      rows_b  <= CFG_RESET;
      cols_b  <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:  rows_a  <= cfg_data;
        REG_INNER_A: inner_a <= cfg_data;
        REG_ROWS_B:  rows_b  <= cfg_data;
        REG_COLS_B:  cols_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  // dimensions clipped to capacity
  always_comb begin
    ra = sat_dim(rows_a);
    ia = sat_dim(inner_a);
    rb = sat_dim(rows_b);
    cb = sat_dim(cols_b);
  end

  assign out_free = !out_valid || out_ready;

  imm_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .ra       (ra),
    .ia       (ia),
    .rb       (rb),
    .cb       (cb),
    .out_free (out_free),
    .mac_busy (mac_busy),
    .ctrl     (ctrl),
    .wr_addr  (wr_addr),
    .rd_a_addr(rd_a_addr),
    .rd_b_addr(rd_b_addr),
    .emit     (emit)
  );

  imm_mac #(
    .MAX_DIM(MAX_DIM)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .wr_addr  (wr_addr),
    .wr_data  (value),
    .rd_a_addr(rd_a_addr),
    .rd_b_addr(rd_b_addr),
    .busy     (mac_busy),
    .acc      (acc)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      product   <= emit.err ? '0 : acc;
      row_index <= emit.row;
      col_index <= emit.col;
      last      <= emit.last;
      dim_error <= emit.err;
    end
  end

  // a new result never overwrites a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> (!out_valid || out_ready))
    else $error("result emitted over a pending output word");

  // a mismatch result carries a zero product
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dim_error) |-> (product == '0))
    else $error("dimension error with nonzero product");

  // a non-empty compute word holds off the input
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (func == FUNC_COMPUTE) && (ra != '0) && (cb != '0))
      |=> !in_ready)
    else $error("input ready during product walk");

  // the multiplier is never fed outside an element walk
  a_issue_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.issue |-> !in_ready)
    else $error("store read issued while idle");

endmodule
